/* sv/dsp_saturating_mac_unit_assert.svh */
// ----------------------------------------------------------------------------
// DSP MAC unit assertion macros
// Shared forms for the concurrent checks of the DSP MAC unit. Each macro
// expects signals named clk and rst in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef DSP_SATURATING_MAC_UNIT_ASSERT_SVH
`define DSP_SATURATING_MAC_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define DSM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset
`define DSM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/dsm_pkg.sv */
// ----------------------------------------------------------------------------
// DSP MAC unit package
// Operation codes, beat types and pipeline stage records.
// ----------------------------------------------------------------------------
package dsm_pkg;

  localparam int WordW = 32;
  localparam int HalfW = 16;
  localparam int ProdW = WordW + HalfW;
  localparam int WideW = 2 * WordW;

  // Operation codes
  localparam logic [3:0] FUNC_QADD  = 4'd0;
  localparam logic [3:0] FUNC_QSUB  = 4'd1;
  localparam logic [3:0] FUNC_QDADD = 4'd2;
  localparam logic [3:0] FUNC_QDSUB = 4'd3;
  localparam logic [3:0] FUNC_SMLA  = 4'd4;
  localparam logic [3:0] FUNC_SMLAW = 4'd5;
  localparam logic [3:0] FUNC_SMUL  = 4'd6;
  localparam logic [3:0] FUNC_SMULW = 4'd7;
  localparam logic [3:0] FUNC_SMLAL = 4'd8;

  localparam logic [WordW-1:0] SAT_MAX = 32'h7FFF_FFFF;
  localparam logic [WordW-1:0] SAT_MIN = 32'h8000_0000;

  // How the final sum becomes a result
  typedef enum logic [2:0] {
    KIND_NONE,  // unused code: all zero
    KIND_SAT,   // saturate to signed 32 bits
    KIND_FLAG,  // wrap to 32 bits, flag signed overflow
    KIND_WRAP,  // wrap to 32 bits, no flag
    KIND_WIDE   // full 64-bit result
  } kind_t;

  typedef struct packed {
    logic [3:0]       func;
    logic [WordW-1:0] operand_m;
    logic [WordW-1:0] operand_s;
    logic [WordW-1:0] operand_n;
    logic [WordW-1:0] acc_lo;
    logic [WordW-1:0] acc_hi;
    logic             m_high;
    logic             s_high;
  } op_t;

  typedef struct packed {
    logic [WordW-1:0] result_lo;
    logic [WordW-1:0] result_hi;
    logic             q_set;
  } res_t;

  // Multiply stage record: adder operands and early flag
  typedef struct packed {
    kind_t            kind;
    logic [WideW-1:0] a;
    logic [WideW-1:0] b;
    logic             sub;
    logic             q;
  } mul_rec_t;

  // Add stage record
  typedef struct packed {
    kind_t            kind;
    logic [WideW-1:0] sum;
    logic             q;
  } add_rec_t;

endpackage

/* sv/dsm_mul_stage.sv */
// ----------------------------------------------------------------------------
// DSP MAC unit multiply stage
// Selects halfwords, forms the 32x16 signed product and the saturated
// doubling, and lines up the two adder operands for the next stage.
// ----------------------------------------------------------------------------
module dsm_mul_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              op_valid,
  input  dsm_pkg::op_t      op,
  output logic              rec_valid,
  output dsm_pkg::mul_rec_t rec
);

  logic [dsm_pkg::HalfW-1:0]        half_m;
  logic [dsm_pkg::HalfW-1:0]        half_s;
  logic [dsm_pkg::WordW-1:0]        mul_a;
  logic                             word_mul;
  logic signed [dsm_pkg::ProdW-1:0] prod;
  logic [dsm_pkg::WordW-1:0]        prod_lo;
  logic [dsm_pkg::WordW-1:0]        prod_mid;
  logic [dsm_pkg::WordW-1:0]        dbl_n;
  logic                             dbl_ovf;
  logic [dsm_pkg::WideW-1:0]        sx_m;
  logic [dsm_pkg::WideW-1:0]        sx_n;
  dsm_pkg::mul_rec_t                rec_next;

  // Pick halfwords and multiplier width
  always_comb begin
    half_m   = op.m_high ? op.operand_m[31:16] : op.operand_m[15:0];
    half_s   = op.s_high ? op.operand_s[31:16] : op.operand_s[15:0];
    word_mul = (op.func == dsm_pkg::FUNC_SMLAW) || (op.func == dsm_pkg::FUNC_SMULW);
    mul_a    = word_mul ? op.operand_m : {{dsm_pkg::HalfW{half_m[15]}}, half_m};
  end

  assign prod     = $signed(mul_a) * $signed(half_s);
  assign prod_lo  = prod[dsm_pkg::WordW-1:0];
  assign prod_mid = prod[dsm_pkg::ProdW-1:dsm_pkg::HalfW];

  // Saturated doubling of operand_n
  always_comb begin
    dbl_ovf = op.operand_n[31] != op.operand_n[30];
    if (dbl_ovf) begin
      dbl_n = op.operand_n[31] ? dsm_pkg::SAT_MIN : dsm_pkg::SAT_MAX;
    end else begin
      dbl_n = {op.operand_n[30:0], 1'b0};
    end
  end

  assign sx_m = {{dsm_pkg::WordW{op.operand_m[31]}}, op.operand_m};
  assign sx_n = {{dsm_pkg::WordW{op.operand_n[31]}}, op.operand_n};

  // Decode into adder operands
  always_comb begin
    rec_next      = '0;
    rec_next.kind = dsm_pkg::KIND_NONE;
    unique case (op.func) inside
      dsm_pkg::FUNC_QADD, dsm_pkg::FUNC_QSUB: begin
        rec_next.kind = dsm_pkg::KIND_SAT;
        rec_next.a    = sx_m;
        rec_next.b    = sx_n;
        rec_next.sub  = op.func == dsm_pkg::FUNC_QSUB;
      end
      dsm_pkg::FUNC_QDADD, dsm_pkg::FUNC_QDSUB: begin
        rec_next.kind = dsm_pkg::KIND_SAT;
        rec_next.a    = sx_m;
        rec_next.b    = {{dsm_pkg::WordW{dbl_n[31]}}, dbl_n};
        rec_next.sub  = op.func == dsm_pkg::FUNC_QDSUB;
        rec_next.q    = dbl_ovf;
      end
      dsm_pkg::FUNC_SMLA: begin
        rec_next.kind = dsm_pkg::KIND_FLAG;
        rec_next.a    = {{dsm_pkg::WordW{prod_lo[31]}}, prod_lo};
        rec_next.b    = sx_n;
      end
      dsm_pkg::FUNC_SMLAW: begin
        rec_next.kind = dsm_pkg::KIND_FLAG;
        rec_next.a    = {{dsm_pkg::WordW{prod_mid[31]}}, prod_mid};
        rec_next.b    = sx_n;
      end
      dsm_pkg::FUNC_SMUL: begin
        rec_next.kind = dsm_pkg::KIND_WRAP;
        rec_next.a    = {{dsm_pkg::WordW{1'b0}}, prod_lo};
      end
      dsm_pkg::FUNC_SMULW: begin
        rec_next.kind = dsm_pkg::KIND_WRAP;
        rec_next.a    = {{dsm_pkg::WordW{1'b0}}, prod_mid};
      end
      dsm_pkg::FUNC_SMLAL: begin
        rec_next.kind = dsm_pkg::KIND_WIDE;
        rec_next.a    = {op.acc_hi, op.acc_lo};
        rec_next.b    = {{dsm_pkg::WordW{prod_lo[31]}}, prod_lo};
      end
      default: begin
        rec_next.kind = dsm_pkg::KIND_NONE;
      end
    endcase
  end

  // Advance the stage valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      rec_valid <= 1'b0;
    end else if (en) begin
      rec_valid <= op_valid;
    end
  end

  // Advance the stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      rec <= rec_next;
    end
  end

endmodule

/* sv/dsm_add_stage.sv */
// ----------------------------------------------------------------------------
// DSP MAC unit add stage
// One shared 64-bit adder/subtractor for every operation.
// ----------------------------------------------------------------------------
module dsm_add_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              rec_valid,
  input  dsm_pkg::mul_rec_t rec,
  output logic              sum_valid,
  output dsm_pkg::add_rec_t sum_rec
);

  logic [dsm_pkg::WideW-1:0] b_eff;
  dsm_pkg::add_rec_t         sum_rec_next;

  // Add, or subtract through inverted operand and carry in
  always_comb begin
    b_eff             = rec.sub ? ~rec.b : rec.b;
    sum_rec_next.kind = rec.kind;
    sum_rec_next.q    = rec.q;
    sum_rec_next.sum  = rec.a + b_eff + {{(dsm_pkg::WideW-1){1'b0}}, rec.sub};
  end

  // Advance the stage valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      sum_valid <= 1'b0;
    end else if (en) begin
      sum_valid <= rec_valid;
    end
  end

  // Advance the stage payload
  always_ff @(posedge clk) begin
    if (en) begin
      sum_rec <= sum_rec_next;
    end
  end

endmodule

/* sv/dsp_saturating_mac_unit.sv */
// ----------------------------------------------------------------------------
// DSP saturating MAC unit
// Execute unit for saturating adds and halfword multiply-accumulates.
// ----------------------------------------------------------------------------
// Usage:
//   Operations enter on the op channel (op_valid/op_ready, payload op) and
//   results leave on the res channel (res_valid/res_ready, payload res).
//   Each accepted op beat yields exactly one res beat, in order.
//   Pipeline: multiply stage, 64-bit add stage, saturate/output stage.
//   A beat accepted on op is registered in the multiply, add and output
//   stages in turn, and is held on res until res_ready takes it.
//   Throughput is one beat per cycle; the 32x16 multiplier and the 64-bit
//   adder each sit in a stage of their own, so nothing recirculates.
//   Stall: when res_ready is low, the output register holds; empty stages
//   behind it still fill, and op_ready drops only once all three are full.
//   No beat is lost or repeated.
//   Reset (rst, synchronous) clears every stage valid bit; payload registers
//   are not reset, and the unit takes a new beat in the first cycle after reset.
// ----------------------------------------------------------------------------
`include "dsp_saturating_mac_unit_assert.svh"

module dsp_saturating_mac_unit (
  input  logic           clk,
  input  logic           rst,
  input  logic           op_valid,
  output logic           op_ready,
  input  dsm_pkg::op_t   op,
  output logic           res_valid,
  input  logic           res_ready,
  output dsm_pkg::res_t  res
);

  logic              mul_en;
  logic              add_en;
  logic              out_en;
  logic              mul_valid;
  dsm_pkg::mul_rec_t mul_rec;
  logic              add_valid;
  dsm_pkg::add_rec_t add_rec;
  logic              ovf;
  dsm_pkg::res_t     res_next;
  dsm_pkg::kind_t    res_kind;

  // Stage enables: a stage moves when it is empty or its successor moves
  assign out_en   = !res_valid || res_ready;
  assign add_en   = !add_valid || out_en;
  assign mul_en   = !mul_valid || add_en;
  assign op_ready = mul_en;

  dsm_mul_stage u_mul (
    .clk       (clk),
    .rst       (rst),
    .en        (mul_en),
    .op_valid  (op_valid),
    .op        (op),
    .rec_valid (mul_valid),
    .rec       (mul_rec)
  );

  dsm_add_stage u_add (
    .clk       (clk),
    .rst       (rst),
    .en        (add_en),
    .rec_valid (mul_valid),
    .rec       (mul_rec),
    .sum_valid (add_valid),
    .sum_rec   (add_rec)
  );

  // Saturate, flag or pass the sum through
  assign ovf = add_rec.sum[63:31] != {33{add_rec.sum[31]}};

  always_comb begin
    res_next = '0;
    case (add_rec.kind)
      dsm_pkg::KIND_SAT: begin
        if (ovf) begin
          res_next.result_lo = add_rec.sum[63] ? dsm_pkg::SAT_MIN : dsm_pkg::SAT_MAX;
        end else begin
          res_next.result_lo = add_rec.sum[31:0];
        end
        res_next.q_set = add_rec.q || ovf;
      end
      dsm_pkg::KIND_FLAG: begin
        res_next.result_lo = add_rec.sum[31:0];
        res_next.q_set     = ovf;
      end
      dsm_pkg::KIND_WRAP: begin
        res_next.result_lo = add_rec.sum[31:0];
      end
      dsm_pkg::KIND_WIDE: begin
        res_next.result_lo = add_rec.sum[31:0];
        res_next.result_hi = add_rec.sum[63:32];
      end
      default: begin
        res_next = '0;
      end
    endcase
  end

  // Output register valid bit
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (out_en) begin
      res_valid <= add_valid;
    end
  end

  // Output register payload
  always_ff @(posedge clk) begin
    if (out_en) begin
      res      <= res_next;
      res_kind <= add_rec.kind;
    end
  end

  // Checks
  `DSM_ASSERT_NEXT(a_accept_fills, op_valid && op_ready, mul_valid,
    "accepted beat did not reach the multiply stage")
  `DSM_ASSERT_NEXT(a_add_hold, add_valid && !out_en,
    add_valid && $stable(add_rec), "add stage changed while stalled")
  `DSM_ASSERT_NOW(a_hi_zero, res_valid && (res_kind != dsm_pkg::KIND_WIDE),
    res.result_hi == '0, "high word nonzero for a 32-bit operation")

endmodule
